// ===== sv/spq_pkg.sv =====
// ----------------------------------------------------------------------------
// spq_pkg
// Shared types and constants for the sorted priority queue.
// ----------------------------------------------------------------------------
package spq_pkg;

    localparam int SPQ_DEPTH   = 16;
    localparam int SPQ_VALUE_W = 16;
    localparam int SPQ_OCC_W   = 5;
    localparam int SPQ_KIND_W  = 2;

    localparam logic [SPQ_KIND_W-1:0] KIND_INSERT  = 2'd0;
    localparam logic [SPQ_KIND_W-1:0] KIND_REMOVE  = 2'd1;
    localparam logic [SPQ_KIND_W-1:0] KIND_REVERSE = 2'd2;

    typedef struct packed {
        logic [SPQ_KIND_W-1:0]  kind;
        logic [SPQ_VALUE_W-1:0] value;
    } spq_in_t;

    typedef struct packed {
        logic [SPQ_VALUE_W-1:0] out_value;
        logic                   out_valid;
        logic                   error;
        logic [SPQ_OCC_W-1:0]   occupancy;
        logic                   ascending_now;
    } spq_out_t;

    typedef struct packed {
        logic ins;
        logic rem;
        logic rev;
    } spq_cmd_t;

    typedef struct packed {
        logic full;
        logic empty;
    } spq_stat_t;

endpackage

// ===== sv/spq_ctrl.sv =====
// ----------------------------------------------------------------------------
// spq_ctrl
// Decodes each accepted beat against the store status into datapath commands
// and produces the result strobe, valid and error flags.
// ----------------------------------------------------------------------------
module spq_ctrl (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           start,
    input  logic [spq_pkg::SPQ_KIND_W-1:0] kind,
    input  spq_pkg::spq_stat_t             stat,
    output spq_pkg::spq_cmd_t              cmd,
    output logic                           done,
    output logic                           out_valid,
    output logic                           error
);
    import spq_pkg::*;

    logic done_reg;
    logic done_next;
    logic valid_reg;
    logic valid_next;
    logic err_reg;
    logic err_next;

    always_comb
    begin
        cmd        = '0;
        err_next   = 1'b0;
        done_next  = start;
        if (start)
        begin
            unique case (kind)
                KIND_INSERT:
                begin
                    cmd.ins  = !stat.full;
                    err_next = stat.full;
                end
                KIND_REMOVE:
                begin
                    cmd.rem  = !stat.empty;
                    err_next = stat.empty;
                end
                KIND_REVERSE:
                begin
                    cmd.rev = 1'b1;
                end
                default:
                begin
                    cmd = '0;
                end
            endcase
        end
        valid_next = cmd.rem;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg  <= 1'b0;
            valid_reg <= 1'b0;
            err_reg   <= 1'b0;
        end
        else
        begin
            done_reg  <= done_next;
            valid_reg <= valid_next;
            err_reg   <= err_next;
        end
    end

    assign done      = done_reg;
    assign out_valid = valid_reg;
    assign error     = err_reg;

endmodule

// ===== sv/spq_datapath.sv =====
// ----------------------------------------------------------------------------
// spq_datapath
// Sorted register chain. The chain is always held in ascending physical
// order; the direction flag selects which end is the front. Every cell
// compares the broadcast value at once and shifts on insert.
// ----------------------------------------------------------------------------
module spq_datapath #(
    parameter int DEPTH = spq_pkg::SPQ_DEPTH
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  spq_pkg::spq_cmd_t               cmd,
    input  logic [spq_pkg::SPQ_VALUE_W-1:0] value,
    output spq_pkg::spq_stat_t              stat,
    output logic [spq_pkg::SPQ_VALUE_W-1:0] out_value,
    output logic [spq_pkg::SPQ_OCC_W-1:0]   occupancy,
    output logic                            ascending_now
);
    import spq_pkg::*;

    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam int IDX_W = $clog2(DEPTH);

    logic [SPQ_VALUE_W-1:0] entry_reg  [DEPTH];
    logic [SPQ_VALUE_W-1:0] entry_next [DEPTH];
    logic [DEPTH-1:0]       at_or_after;
    logic [CNT_W-1:0]       count_reg;
    logic [CNT_W-1:0]       count_next;
    logic                   asc_reg;
    logic                   asc_next;
    logic [SPQ_VALUE_W-1:0] out_value_reg;
    logic [SPQ_VALUE_W-1:0] out_value_next;
    logic [IDX_W-1:0]       back_idx;
    logic [SPQ_VALUE_W-1:0] front;

    // mark cells at or beyond the insertion point
    for (genvar i = 0; i < DEPTH; i++)
    begin : g_cmp
        always_comb
        begin
            if (CNT_W'(i) < count_reg)
            begin
                at_or_after[i] = asc_reg ? (value < entry_reg[i])
                                         : (value <= entry_reg[i]);
            end
            else
            begin
                at_or_after[i] = 1'b1;
            end
        end
    end

    for (genvar i = 0; i < DEPTH; i++)
    begin : g_next
        always_comb
        begin
            entry_next[i] = entry_reg[i];
            if (cmd.ins && at_or_after[i])
            begin
                if (i > 0 && at_or_after[(i > 0) ? i - 1 : 0])
                begin
                    entry_next[i] = entry_reg[(i > 0) ? i - 1 : 0];
                end
                else
                begin
                    entry_next[i] = value;
                end
            end
            else if (cmd.rem && asc_reg && i < DEPTH - 1)
            begin
                entry_next[i] = entry_reg[(i < DEPTH - 1) ? i + 1 : i];
            end
        end
    end

    assign back_idx = IDX_W'(count_reg - CNT_W'(1));
    assign front    = asc_reg ? entry_reg[0] : entry_reg[back_idx];

    always_comb
    begin
        count_next     = count_reg;
        asc_next       = asc_reg;
        out_value_next = '0;
        if (cmd.ins)
        begin
            count_next = count_reg + CNT_W'(1);
        end
        if (cmd.rem)
        begin
            count_next     = count_reg - CNT_W'(1);
            out_value_next = front;
        end
        if (cmd.rev)
        begin
            asc_next = !asc_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            asc_reg   <= 1'b1;
        end
        else
        begin
            count_reg <= count_next;
            asc_reg   <= asc_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_value_reg <= out_value_next;
        for (int i = 0; i < DEPTH; i++)
        begin
            entry_reg[i] <= entry_next[i];
        end
    end

    assign stat.full     = (count_reg == CNT_W'(DEPTH));
    assign stat.empty    = (count_reg == '0);
    assign out_value     = out_value_reg;
    assign occupancy     = SPQ_OCC_W'(count_reg);
    assign ascending_now = asc_reg;

endmodule

// ===== sv/sorted_priority_queue_top.sv =====
// ----------------------------------------------------------------------------
// sorted_priority_queue_top
// Bounded priority queue held as a sorted register chain.
// ----------------------------------------------------------------------------
// Beats never wait: busy stays low, a request accepted at a clock edge
// yields its result with done high during the following cycle, and a new
// request may be issued every cycle. The rate is set by the register chain,
// where all entries compare the inserted value in parallel and shift in the
// same cycle. Results must be taken in the cycle they are shown; the
// receiver cannot hold them off. Occupancy and direction reflect the store
// after the operation.
// ----------------------------------------------------------------------------
module sorted_priority_queue_top #(
    parameter int DEPTH = spq_pkg::SPQ_DEPTH
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    output logic              busy,
    input  spq_pkg::spq_in_t  request,
    output logic              done,
    output spq_pkg::spq_out_t result
);
    import spq_pkg::*;

    spq_cmd_t  cmd;
    spq_stat_t stat;
    logic      accept;

    assign busy   = 1'b0;
    assign accept = start && !busy;

    spq_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (accept),
        .kind      (request.kind),
        .stat      (stat),
        .cmd       (cmd),
        .done      (done),
        .out_valid (result.out_valid),
        .error     (result.error)
    );

    spq_datapath #(
        .DEPTH (DEPTH)
    ) u_datapath (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .value         (request.value),
        .stat          (stat),
        .out_value     (result.out_value),
        .occupancy     (result.occupancy),
        .ascending_now (result.ascending_now)
    );

    a_valid_not_error : assert property (@(posedge clk) disable iff (!rst_n)
        result.out_valid |-> (!result.error && done))
        else $error("valid and error both set");

    a_remove_drops_count : assert property (@(posedge clk) disable iff (!rst_n)
        (done && result.out_valid) |->
            (result.occupancy == $past(result.occupancy) - 5'd1))
        else $error("remove did not reduce occupancy");

    a_reverse_toggles : assert property (@(posedge clk) disable iff (!rst_n)
        (accept && request.kind == KIND_REVERSE) |=>
            (result.ascending_now != $past(result.ascending_now)))
        else $error("reverse did not toggle direction");

    a_error_keeps_count : assert property (@(posedge clk) disable iff (!rst_n)
        (done && result.error) |-> $stable(result.occupancy))
        else $error("failed operation changed occupancy");

endmodule
